// ----- rtl/core/div128_pkg.sv -----
// types and constants for the 128-by-64 restoring divider
// no dependencies; imported by every module of the divider core
package div128_pkg;

	localparam int unsigned DATA_W  = 64;
	localparam int unsigned DIVD_W  = 2 * DATA_W;
	// one restoring step per pipeline stage
	localparam int unsigned STEPS   = DIVD_W;
	// entry stage, step stages, result register
	localparam int unsigned LATENCY = STEPS + 2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] dividend_high;
		logic [DATA_W-1:0] dividend_low;
		logic [DATA_W-1:0] divisor;
	} div128_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
		logic [1:0]        status;
	} div128_out_t;

	// payload carried from stage to stage
	// bits: dividend bits still to shift in on top, quotient bits collected below
	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DIVD_W-1:0] bits;
		logic [DATA_W-1:0] divisor;
		logic [1:0]        status;
	} div128_stage_t;

endpackage

// ----- rtl/core/div128_step.sv -----
// one registered restoring division step: shift in a dividend bit, trial subtract
// depends on div128_pkg
module div128_step import div128_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  div128_stage_t stage_in,
	output logic          vld_out,
	output div128_stage_t stage_out
);

	logic [DATA_W:0]   trial;
	logic [DATA_W+1:0] diff;
	logic              qbit;
	logic              vld_s1;
	div128_stage_t     stage_s1;
	div128_stage_t     stage_nxt;

	// trial subtract of the divisor from the widened partial remainder
	always_comb begin
		trial = {stage_in.rem, stage_in.bits[DIVD_W-1]};
		diff  = {1'b0, trial} - {2'b00, stage_in.divisor};
		qbit  = ~diff[DATA_W+1];
		stage_nxt         = stage_in;
		stage_nxt.rem     = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
		stage_nxt.bits    = {stage_in.bits[DIVD_W-2:0], qbit};
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		stage_s1 <= stage_nxt;
	end

	assign vld_out   = vld_s1;
	assign stage_out = stage_s1;

endmodule

// ----- rtl/core/divide_128_by_64_core.sv -----
// top level of the pipelined 128-by-64 unsigned restoring divider
// depends on div128_pkg and div128_step
//
// channel    | ports                         | handshake
// -----------+-------------------------------+---------------------------------
// operands   | start, busy, operands         | taken when start high, busy low
// result     | done, result                  | one-cycle strobe, cannot stall
//
// one transaction may enter every cycle; busy is never raised
// a result passes the entry register, 128 step stages and the result register
// each step stage holds one 66-bit trial subtract, which sets the clock
// reset clears only the valid bits; payload registers are not reset
module divide_128_by_64_core import div128_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  div128_in_t  operands,
	output logic        done,
	output div128_out_t result
);

	logic          ent_vld_s1;
	div128_stage_t ent_data_s1;
	div128_stage_t ent_nxt;
	logic          step_vld  [0:STEPS];
	div128_stage_t step_data [0:STEPS];
	logic          done_q;
	div128_out_t   result_q;
	div128_out_t   result_nxt;

	assign busy = 1'b0;

	// entry: classify the transaction and load the shift register
	always_comb begin
		ent_nxt.rem     = '0;
		ent_nxt.bits    = {operands.dividend_high, operands.dividend_low};
		ent_nxt.divisor = operands.divisor;
		if (operands.divisor == '0) begin
			ent_nxt.status = STATUS_DIV_ZERO;
		end else if (operands.dividend_high >= operands.divisor) begin
			ent_nxt.status = STATUS_OVERFLOW;
		end else begin
			ent_nxt.status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_s1 <= 1'b0;
		end else begin
			ent_vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		ent_data_s1 <= ent_nxt;
	end

	assign step_vld[0]  = ent_vld_s1;
	assign step_data[0] = ent_data_s1;

	// chain of restoring steps, one dividend bit per stage
	for (genvar g = 0; g < STEPS; g++) begin : g_step
		div128_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.vld_in    (step_vld[g]),
			.stage_in  (step_data[g]),
			.vld_out   (step_vld[g+1]),
			.stage_out (step_data[g+1])
		);
	end

	// result: low quotient bits and remainder, zeroed on divide by zero
	always_comb begin
		result_nxt.quotient  = step_data[STEPS].bits[DATA_W-1:0];
		result_nxt.remainder = step_data[STEPS].rem;
		result_nxt.status    = step_data[STEPS].status;
		if (step_data[STEPS].status == STATUS_DIV_ZERO) begin
			result_nxt.quotient  = '0;
			result_nxt.remainder = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= step_vld[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_nxt;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/core/div128_checker.sv -----
// port-level checks for the divider core, bound to the top level
// depends on div128_pkg and divide_128_by_64_core
module div128_checker import div128_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input div128_in_t  operands,
	input logic        done,
	input div128_out_t result
);

	// the core never pushes back
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");

	// status code is one of the three defined
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == STATUS_OK || result.status == STATUS_DIV_ZERO
			|| result.status == STATUS_OVERFLOW)) else $error("bad status code");

	// divide by zero flag matches the divisor taken at entry
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.status == STATUS_DIV_ZERO)
			== ($past(operands.divisor, LATENCY) == '0)))
		else $error("divide by zero flag mismatch");

	// zero divisor gives zero quotient and remainder
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == STATUS_DIV_ZERO |->
			result.quotient == '0 && result.remainder == '0)
		else $error("nonzero result on divide by zero");

	// remainder stays below the divisor of the same transaction
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != STATUS_DIV_ZERO |->
			result.remainder < $past(operands.divisor, LATENCY))
		else $error("remainder not below divisor");

endmodule

bind divide_128_by_64_core div128_checker u_div128_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.operands (operands),
	.done     (done),
	.result   (result)
);
